/* sv/ili_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ili_pkg: shared types for the indexed list
// Command and status codes, and the control word that the top level
// broadcasts to every storage cell of the chain.
// ----------------------------------------------------------------------------
package ili_pkg;

    // Width of an index or count wide enough for the largest supported capacity.
    localparam int POS_W = 11;

    // Width of the list length field on the result port.
    localparam int LEN_W = 7;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_WRITE  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Broadcast control for the cell chain; at most one action flag is set.
    typedef struct packed {
        logic             do_insert;
        logic             do_remove;
        logic             do_write;
        logic [POS_W-1:0] pos;
    } cell_ctl_t;

endpackage

/* sv/indexed_list_insert_remove.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove: ordered word list with insert and remove
// A row of storage cells keeps the list; insert and remove shift every
// affected entry by one place at the same clock edge.
//
//   Channel  Signals                               Direction
//   command  start, busy, command, position,       in (busy out)
//            data_word
//   result   done, read_word, list_length, status  out
//
// One word is taken per cycle: busy stays low, since every command finishes
// in the cycle it is accepted, shifting the whole cell row in that edge.
// The result appears on the cycle after acceptance, marked by done for
// exactly one cycle. The receiver cannot stall the result port.
// Reset clears the length to zero; entry contents are undefined until
// written and are never read before that.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove
    import ili_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [6:0]  position,
    input  logic [31:0] data_word,
    output logic        done,
    output logic [31:0] read_word,
    output logic [6:0]  list_length,
    output logic [1:0]  status
);

    localparam int               CNT_W = $clog2(CAPACITY + 1);
    localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

    logic                  accept;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [POS_W-1:0]      cnt_ext;
    logic [POS_W-1:0]      pos_ext;
    logic [DATA_WIDTH-1:0] word;
    cell_ctl_t             ctl;
    status_t               st;
    logic                  rd_ok;
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_bus;
    logic                  done_reg;
    logic [31:0]           read_word_reg;
    logic [6:0]            list_length_reg;
    status_t               status_reg;
    logic [POS_W-1:0]      len_ext;

    // Every command completes in its own cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign cnt_ext = POS_W'(cnt_reg);
    assign pos_ext = POS_W'(position);
    assign word    = DATA_WIDTH'(data_word);

    // Command decode: range and full checks, cell control and new length.
    always_comb
    begin
        ctl       = '0;
        ctl.pos   = pos_ext;
        cnt_next  = cnt_reg;
        st        = ST_OK;
        rd_ok     = 1'b0;
        case (command)
            OP_APPEND:
            begin
                if (cnt_ext >= CAP_P)
                    st = ST_FULL;
                else
                begin
                    ctl.do_write = accept;
                    ctl.pos      = cnt_ext;
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
            end
            OP_INSERT:
            begin
                if (pos_ext > cnt_ext)
                    st = ST_RANGE;
                else if (cnt_ext >= CAP_P)
                    st = ST_FULL;
                else
                begin
                    ctl.do_insert = accept;
                    cnt_next      = cnt_reg + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (pos_ext >= cnt_ext)
                    st = ST_RANGE;
                else
                begin
                    ctl.do_remove = accept;
                    cnt_next      = cnt_reg - CNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (pos_ext >= cnt_ext)
                    st = ST_RANGE;
                else
                    rd_ok = 1'b1;
            end
            OP_WRITE:
            begin
                if (pos_ext >= cnt_ext)
                    st = ST_RANGE;
                else
                    ctl.do_write = accept;
            end
            default:
            begin
                st = ST_RANGE;
            end
        endcase
    end

    // The row of cells; the ends see the new word and zero as neighbors.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lower_d;
        logic [DATA_WIDTH-1:0] upper_d;

        if (g == 0)
        begin : g_first
            assign lower_d = word;
        end
        else
        begin : g_mid_lo
            assign lower_d = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign upper_d = '0;
        end
        else
        begin : g_mid_hi
            assign upper_d = cell_data[g+1];
        end

        ili_cell #(
            .IDX        (g),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .word       (word),
            .lower_data (lower_d),
            .upper_data (upper_d),
            .data       (cell_data[g]),
            .read_data  (cell_rd[g])
        );
    end

    // Read bus: only the selected cell drives a nonzero word.
    always_comb
    begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_bus = rd_bus | cell_rd[i];
    end

    // Length register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (accept)
            cnt_reg <= cnt_next;
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= accept;
    end

    assign len_ext = POS_W'(cnt_next);

    // Result word registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_word_reg   <= rd_ok ? 32'(rd_bus) : '0;
            list_length_reg <= len_ext[LEN_W-1:0];
            status_reg      <= st;
        end
    end

    assign done        = done_reg;
    assign read_word   = read_word_reg;
    assign list_length = list_length_reg;
    assign status      = status_reg;

`ifndef SYNTHESIS
    // Each accepted command yields exactly one result on the next cycle.
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted command gave no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without a command");

    // The length never exceeds the capacity.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        POS_W'(cnt_reg) <= CAP_P)
        else $error("length beyond capacity");

    // A failed command leaves the length unchanged.
    a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg != ST_OK) |-> (cnt_reg == $past(cnt_reg)))
        else $error("length changed on an error");

    // A full report only occurs with the list at capacity.
    a_full_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_FULL) |-> (POS_W'(cnt_reg) == CAP_P))
        else $error("full status below capacity");
`endif

endmodule

/* sv/ili_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ili_cell: one entry of the list
// Holds one data word. On insert it takes its lower neighbor's word (or the
// new word at the insert point); on remove it takes its upper neighbor's word.
// On write it loads the new word at its index, and it drives its word onto the read bus when selected.
// ----------------------------------------------------------------------------
module ili_cell
    import ili_pkg::*;
#(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  cell_ctl_t             ctl,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] lower_data,
    input  logic [DATA_WIDTH-1:0] upper_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic [DATA_WIDTH-1:0] read_data
);

    localparam logic [POS_W-1:0] IDX_P = POS_W'(IDX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  hit;
    logic                  above;

    assign hit   = (ctl.pos == IDX_P);
    assign above = (IDX_P > ctl.pos);

    // Next word: shift up, shift down, load the new word, or hold.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.do_insert)
        begin
            if (above)
                data_next = lower_data;
            else if (hit)
                data_next = word;
        end
        else if (ctl.do_remove)
        begin
            if (above || hit)
                data_next = upper_data;
        end
        else if (ctl.do_write && hit)
        begin
            data_next = word;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign read_data = hit ? data_reg : '0;

endmodule

/* test/indexed_list_insert_remove_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_tb: self-checking bench for the indexed list
// A short directed run covers empty and out-of-range accesses, edge values
// and unused command codes. Random runs then grow the list to full and
// shrink it to empty again and again. Each command word is predicted by a
// local copy of the list, and every done word is checked against it.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_tb;
    import ili_pkg::*;

    localparam int LIST_CAP = 64;
    localparam int LIST_IDX_W = $clog2(LIST_CAP);
    localparam int RANDOM_WORDS = 900;
    localparam int LIMIT_CYCLES = 100000;
    localparam int POS_MAX = 127;
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] CMD_UNUSED_LAST = 3'd7;

    typedef struct {
        logic [2:0]  command;
        logic [6:0]  position;
        logic [31:0] data_word;
        bit          drain_first;
    } cmd_word_t;

    typedef struct {
        logic [31:0] read_word;
        logic [6:0]  list_length;
        status_t     status;
    } list_result_t;

    logic        clk;
    logic        rst_n;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  command = OP_APPEND;
    logic [6:0]  position = '0;
    logic [31:0] data_word = '0;
    logic        done;
    logic [31:0] read_word;
    logic [6:0]  list_length;
    logic [1:0]  status;

    cmd_word_t    queued_commands[$];
    list_result_t awaited_results[$];
    logic [31:0]  list_mem[LIST_CAP];
    int           list_len;
    int           gen_len;
    int           errors;
    int           cycle_count;
    int           sent_count;
    bit           word_taken;

    indexed_list_insert_remove dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .position   (position),
        .data_word  (data_word),
        .done       (done),
        .read_word  (read_word),
        .list_length(list_length),
        .status     (status)
    );

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Apply one command to the local copy of the list and return its result.
    function automatic list_result_t apply_list_command(cmd_word_t w);
        list_result_t r;
        int k;
        int wpos;
        r.read_word = '0;
        r.status = ST_OK;
        wpos = int'(w.position);
        case (w.command)
            OP_APPEND:
            begin
                if (list_len >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    list_mem[LIST_IDX_W'(list_len)] = w.data_word;
                    list_len++;
                end
            end
            OP_INSERT:
            begin
                if (wpos > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= LIST_CAP)
                    r.status = ST_FULL;
                else
                begin
                    for (k = list_len; k > wpos; k--)
                        list_mem[LIST_IDX_W'(k)] = list_mem[LIST_IDX_W'(k - 1)];
                    list_mem[LIST_IDX_W'(wpos)] = w.data_word;
                    list_len++;
                end
            end
            OP_REMOVE:
            begin
                if (wpos >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (k = wpos; k + 1 < list_len; k++)
                        list_mem[LIST_IDX_W'(k)] = list_mem[LIST_IDX_W'(k + 1)];
                    list_len--;
                end
            end
            OP_READ:
            begin
                if (wpos >= list_len)
                    r.status = ST_RANGE;
                else
                    r.read_word = list_mem[LIST_IDX_W'(wpos)];
            end
            OP_WRITE:
            begin
                if (wpos >= list_len)
                    r.status = ST_RANGE;
                else
                    list_mem[LIST_IDX_W'(wpos)] = w.data_word;
            end
            default:
                r.status = ST_RANGE;
        endcase
        r.list_length = list_len[6:0];
        return r;
    endfunction

    // Length of the list after a command, used to aim generated positions.
    function automatic int length_after(logic [2:0] c, int p, int n);
        case (c)
            OP_APPEND: return (n < LIST_CAP) ? n + 1 : n;
            OP_INSERT: return (p <= n && n < LIST_CAP) ? n + 1 : n;
            OP_REMOVE: return (p < n) ? n - 1 : n;
            default:   return n;
        endcase
    endfunction

    task automatic queue_word(logic [2:0] c, int p, logic [31:0] d, bit drain);
        cmd_word_t w;
        w.command = c;
        w.position = p[6:0];
        w.data_word = d;
        w.drain_first = drain;
        queued_commands.push_back(w);
        gen_len = length_after(c, p, gen_len);
    endtask

    // Stimulus: directed words, then random grow and shrink phases.
    initial
    begin : stimulus
        bit growing;
        int full_hold;
        int roll;
        int p;
        logic [2:0] c;
        logic [31:0] d;
        gen_len = 0;

        // Accesses to an empty list are all out of range.
        queue_word(OP_READ, 0, 32'h0, 1'b0);
        queue_word(OP_REMOVE, 0, 32'h0, 1'b0);
        queue_word(OP_WRITE, 0, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_INSERT, 1, 32'h1234_5678, 1'b0);
        // Build a short list through both ends and the middle.
        queue_word(OP_APPEND, 0, 32'h0000_0000, 1'b0);
        queue_word(OP_APPEND, POS_MAX, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_INSERT, 0, 32'hA5A5_5A5A, 1'b0);
        queue_word(OP_INSERT, 3, 32'h0123_4567, 1'b0);
        queue_word(OP_INSERT, 2, 32'h8000_0001, 1'b0);
        for (int i = 0; i < 5; i++)
            queue_word(OP_READ, i, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_WRITE, 4, 32'h7FFF_FFFF, 1'b0);
        queue_word(OP_READ, 4, 32'h0, 1'b0);
        // Remove the first and the last entry; the old last slot is then invalid.
        queue_word(OP_REMOVE, 0, 32'h0, 1'b0);
        queue_word(OP_REMOVE, 3, 32'h0, 1'b0);
        queue_word(OP_READ, 3, 32'h0, 1'b0);
        // Unused command codes change nothing.
        for (int i = CMD_UNUSED_FIRST; i <= CMD_UNUSED_LAST; i++)
            queue_word(i[2:0], POS_MAX, 32'hFFFF_FFFF, 1'b0);
        queue_word(OP_READ, POS_MAX, 32'h0, 1'b0);
        queue_word(OP_REMOVE, LIST_CAP, 32'h0, 1'b0);

        // Random phases: grow until full, linger there, then shrink to empty.
        growing = 1'b1;
        full_hold = 0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (growing && gen_len == LIST_CAP)
            begin
                full_hold++;
                if (full_hold >= 6)
                begin
                    growing = 1'b0;
                    full_hold = 0;
                end
            end
            else if (!growing && gen_len == 0)
                growing = 1'b1;
            else if ($urandom_range(99) < 2)
                growing = !growing;

            roll = $urandom_range(99);
            if (growing)
                c = (roll < 35) ? OP_APPEND : (roll < 65) ? OP_INSERT :
                    (roll < 72) ? OP_REMOVE : (roll < 84) ? OP_READ :
                    (roll < 94) ? OP_WRITE : CMD_UNUSED_FIRST;
            else
                c = (roll < 5) ? OP_APPEND : (roll < 12) ? OP_INSERT :
                    (roll < 55) ? OP_REMOVE : (roll < 75) ? OP_READ :
                    (roll < 93) ? OP_WRITE : CMD_UNUSED_FIRST;

            if (c == CMD_UNUSED_FIRST)
            begin
                // Noise: unused codes, or any command at any position.
                if ($urandom_range(1))
                    c = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
                else
                    c = 3'($urandom_range(OP_WRITE, OP_APPEND));
                p = $urandom_range(POS_MAX);
            end
            else if (c == OP_INSERT)
                p = $urandom_range(gen_len);
            else if (gen_len == 0)
                p = $urandom_range(POS_MAX);
            else
                p = $urandom_range(gen_len - 1);

            roll = $urandom_range(99);
            d = (roll < 5) ? 32'h0 : (roll < 10) ? 32'hFFFF_FFFF : $urandom();
            queue_word(c, p, d, n == 0 || n == 300 || n == 700);
        end

        // Wait for the last word to drain and its result to be checked, then report.
        do
            @(posedge clk);
        while (queued_commands.size() != 0 || start || awaited_results.size() != 0);
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Driver: presents the next command word at the falling edge.
    always @(negedge clk)
    begin : drive_words
        cmd_word_t w;
        bit idle_now;
        if (rst_n && (!start || word_taken))
        begin
            // No idling inside one long stretch of the run.
            idle_now = !(sent_count >= 400 && sent_count < 650)
                && ($urandom_range(99) < 6);
            if (queued_commands.size() == 0 || idle_now
                || (queued_commands[0].drain_first && awaited_results.size() != 0))
                start <= 1'b0;
            else
            begin
                w = queued_commands.pop_front();
                command <= w.command;
                position <= w.position;
                data_word <= w.data_word;
                start <= 1'b1;
                sent_count++;
            end
        end
    end

    // Monitor: checks done words, then predicts any word taken at this edge.
    always @(posedge clk)
    begin : watch_words
        list_result_t expected_r;
        cmd_word_t w;
        cycle_count++;
        if (!rst_n)
        begin
            word_taken = 1'b0;
            list_len = 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %h/%0d/%0d",
                        $time, read_word, list_length, status);
                end
                else
                begin
                    expected_r = awaited_results.pop_front();
                    if (read_word !== expected_r.read_word)
                    begin
                        errors++;
                        $display("%0t: read_word mismatch, expected %h, got %h",
                            $time, expected_r.read_word, read_word);
                    end
                    if (list_length !== expected_r.list_length)
                    begin
                        errors++;
                        $display("%0t: list_length mismatch, expected %0d, got %0d",
                            $time, expected_r.list_length, list_length);
                    end
                    if (status !== expected_r.status)
                    begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                            $time, expected_r.status, status);
                    end
                end
            end
            word_taken = start && !busy;
            if (word_taken)
            begin
                w.command = command;
                w.position = position;
                w.data_word = data_word;
                w.drain_first = 1'b0;
                awaited_results.push_back(apply_list_command(w));
            end
        end
    end

    // Watchdog on the cycle count.
    initial
    begin
        wait (cycle_count >= LIMIT_CYCLES);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
